// ===== rtl/kmau_pkg.sv =====
// kmau_pkg: types and constants shared by the k-means assign/update block
// no dependencies
package kmau_pkg;

  localparam int DIMS = 4;
  localparam int SUM_BITS = 32;
  localparam int CFG_BITS = 5;
  localparam int TYPE_BITS = 2;
  localparam int IDX_BITS = 4;
  localparam int FIELD_BITS = 16;

  localparam logic [TYPE_BITS-1:0] REQ_LOAD   = 2'd0;
  localparam logic [TYPE_BITS-1:0] REQ_ASSIGN = 2'd1;
  localparam logic [TYPE_BITS-1:0] REQ_UPDATE = 2'd2;

  typedef struct packed {
    logic [TYPE_BITS-1:0]  req_type;
    logic [IDX_BITS-1:0]   centroid_index;
    logic signed [FIELD_BITS-1:0] coord_a;
    logic signed [FIELD_BITS-1:0] coord_b;
    logic signed [FIELD_BITS-1:0] coord_c;
    logic signed [FIELD_BITS-1:0] coord_d;
  } req_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]  nearest_cluster;
    logic                 converged;
    logic [TYPE_BITS-1:0] answered_type;
  } rsp_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;

endpackage

// ===== rtl/kmau_req_if.sv =====
// kmau_req_if, kmau_rsp_if, kmau_cfg_if: valid/ready channels of the block
// depends on kmau_pkg
interface kmau_req_if import kmau_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kmau_rsp_if import kmau_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kmau_cfg_if import kmau_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_BITS-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/kmau_div.sv =====
// kmau_div: restoring divider, one quotient bit per cycle, truncating
// depends on kmau_pkg
module kmau_div import kmau_pkg::*; #(
  parameter int CntBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_ctl_t            ctl_i,
  input  logic [SUM_BITS-1:0] mag_i,
  input  logic [CntBits-1:0]  den_i,
  output logic                done_o,
  output logic [SUM_BITS-1:0] quot_o
);

  localparam int StepBits = $clog2(SUM_BITS + 1);

  logic [SUM_BITS-1:0] num_q, num_d;
  logic [CntBits:0]    rem_q, rem_d;
  logic [CntBits-1:0]  den_q;
  logic [StepBits-1:0] step_q, step_d;
  logic                busy_q, busy_d, neg_q;
  logic                done_q;
  logic [CntBits:0]    trial;

  assign trial = {rem_q[CntBits-1:0], num_q[SUM_BITS-1]};

  // one shift and subtract each cycle
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    if (ctl_i.start) begin
      num_d  = mag_i;
      rem_d  = '0;
      step_d = StepBits'(SUM_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[SUM_BITS-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepBits'(1)) busy_d = 1'b0;
    end
  end

  // done is raised once the last quotient bit is in num_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= busy_q && !busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (ctl_i.start) begin
      den_q <= den_i;
      neg_q <= ctl_i.neg;
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~num_q + 1'b1) : num_q;

endmodule

// ===== rtl/kmau_dist.sv =====
// kmau_dist: two-stage squared distance of a point to one centroid
// depends on kmau_pkg
module kmau_dist import kmau_pkg::*; #(
  parameter int CoordBits = 16
) (
  input  logic                         clk_i,
  input  logic [DIMS*CoordBits-1:0]    pt_i,
  input  logic [DIMS*CoordBits-1:0]    cen_i,
  output logic [2*CoordBits+2:0]       dist_o
);

  localparam int DiffBits = CoordBits + 1;
  localparam int SqBits = 2 * CoordBits;

  logic [DIMS-1:0][SqBits:0] sq_q;

  // stage 1: per-dimension squares
  always_ff @(posedge clk_i) begin
    for (int d = 0; d < DIMS; d++) begin
      logic signed [DiffBits-1:0] df;
      logic signed [2*DiffBits-1:0] pr;
      df = DiffBits'($signed(pt_i[d*CoordBits +: CoordBits]))
         - DiffBits'($signed(cen_i[d*CoordBits +: CoordBits]));
      pr = df * df;
      sq_q[d] <= pr[SqBits:0];
    end
  end

  // stage 2: sum
  assign dist_o = (SqBits+3)'(sq_q[0]) + (SqBits+3)'(sq_q[1])
                + (SqBits+3)'(sq_q[2]) + (SqBits+3)'(sq_q[3]);

endmodule

// ===== rtl/kmeans_assign_update.sv =====
// k-means assign/update block (Lloyd step on 4-d signed Q4.12 points)
// Channels: req (sink) carries load/assign/update requests, rsp (source)
// returns one response transaction per request, cfg (sink) writes the
// number of active centroids (0 acts as 1, above MAX_CENTROIDS saturates).
// Centroids, sums and counts live in synchronous memories with a registered
// read port; after reset a clearing pass over all MAX_CENTROIDS entries
// zeroes them while req.ready is low.
// Load writes the centroid memory as the request is taken; assign reads one
// centroid per cycle, then does a read-modify-write of the sums; update
// sweeps all MAX_CENTROIDS entries, and for a filled cluster the one shared
// bit-serial divider forms each coordinate mean. One request is in work at a time.
// A finished response is held in an output register; when the receiver
// stalls the block waits there before taking the next request.
// Responses of request type three change nothing and echo the type.
module kmeans_assign_update import kmau_pkg::*; #(
  parameter int MAX_CENTROIDS = 16,
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  kmau_cfg_if.sink    cfg,
  kmau_req_if.sink    req,
  kmau_rsp_if.source  rsp
);

  localparam int AW = $clog2(MAX_CENTROIDS);
  localparam int NB = AW + 1;
  localparam int CW = DIMS * COORD_BITS;
  localparam int SW = DIMS * SUM_BITS;
  localparam int DW = 2 * COORD_BITS + 3;

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_ASN = 4'd2,
                         S_ASN_W = 4'd3, S_UPD_RD = 4'd4, S_UPD_DIV = 4'd5,
                         S_UPD_WT = 4'd6, S_UPD_WR = 4'd7, S_RSP = 4'd8,
                         S_ASN_RMW = 4'd9;

  // memories
  logic [CW-1:0]         cen_mem [MAX_CENTROIDS];
  logic [SW-1:0]         sum_mem [MAX_CENTROIDS];
  logic [COUNT_BITS-1:0] cnt_mem [MAX_CENTROIDS];
  logic [CW-1:0]         cen_rd_q;
  logic [SW-1:0]         sum_rd_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;

  logic [3:0]     st_q;
  logic [CFG_BITS-1:0] act_q;
  logic [NB-1:0]  ptr_q;       // read address / sweep pointer
  logic [NB-1:0]  cmp_q;       // index of centroid whose data is in stage
  logic           cmp_v_q, cmp_v2_q;
  logic [AW-1:0]  cmp2_q;
  logic [NB-1:0]  n_used;
  logic [CW-1:0]  pt_q;
  logic [AW-1:0]  best_idx_q;
  logic [DW-1:0]  best_q, sq_dist;
  logic           have_best_q;
  logic [1:0]     dim_q;
  logic [CW-1:0]  mean_q;
  logic           same_q;
  rsp_t           rsp_q;
  logic           rsp_v_q;

  // memory ports
  logic           cen_we, sum_we;
  logic [AW-1:0]  cen_wa, sum_wa, rd_a;
  logic [CW-1:0]  cen_wd;
  logic [SW-1:0]  sum_wd;
  logic [COUNT_BITS-1:0] cnt_wd;

  always_comb begin
    n_used = NB'(act_q);
    if (act_q == '0) n_used = NB'(1);
    if (32'(act_q) > MAX_CENTROIDS) n_used = NB'(MAX_CENTROIDS);
  end

  assign cfg.ready = 1'b1;
  assign req.ready = (st_q == S_IDLE) && !rsp_v_q;
  assign rsp.valid = rsp_v_q;
  assign rsp.data  = rsp_q;

  always_ff @(posedge clk_i) begin
    if (cen_we) cen_mem[cen_wa] <= cen_wd;
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
      cnt_mem[sum_wa] <= cnt_wd;
    end
    cen_rd_q <= cen_mem[rd_a];
    sum_rd_q <= sum_mem[rd_a];
    cnt_rd_q <= cnt_mem[rd_a];
  end

  kmau_dist #(.CoordBits(COORD_BITS)) u_dist (
    .clk_i (clk_i), .pt_i (pt_q), .cen_i (cen_rd_q), .dist_o (sq_dist)
  );

  // divider on one signed sum of the current cluster
  div_ctl_t div_ctl;
  logic signed [SUM_BITS-1:0] sum_sel;
  logic [SUM_BITS-1:0] sum_mag, quot;
  logic div_done;
  assign sum_sel = sum_rd_q[dim_q*SUM_BITS +: SUM_BITS];
  assign sum_mag = sum_sel[SUM_BITS-1] ? (~sum_sel + 1'b1) : sum_sel;

  kmau_div #(.CntBits(COUNT_BITS)) u_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (div_ctl), .mag_i (sum_mag),
    .den_i (cnt_rd_q), .done_o (div_done), .quot_o (quot)
  );

  logic [CW-1:0] pt_in;
  assign pt_in = {req.data.coord_d[COORD_BITS-1:0], req.data.coord_c[COORD_BITS-1:0],
                  req.data.coord_b[COORD_BITS-1:0], req.data.coord_a[COORD_BITS-1:0]};

  // new sums for the chosen cluster
  logic [SW-1:0] sum_add;
  always_comb begin
    for (int d = 0; d < DIMS; d++)
      sum_add[d*SUM_BITS +: SUM_BITS] = sum_rd_q[d*SUM_BITS +: SUM_BITS]
        + SUM_BITS'($signed(pt_q[d*COORD_BITS +: COORD_BITS]));
  end

  logic [CW-1:0] mean_next;
  always_comb begin
    mean_next = mean_q;
    mean_next[dim_q*COORD_BITS +: COORD_BITS] = quot[COORD_BITS-1:0];
  end

  logic req_fire;
  assign req_fire = req.valid && req.ready;

  // control sequencer
  always_comb begin
    cen_we = 1'b0; cen_wa = ptr_q[AW-1:0]; cen_wd = '0;
    sum_we = 1'b0; sum_wa = ptr_q[AW-1:0]; sum_wd = '0; cnt_wd = '0;
    rd_a = ptr_q[AW-1:0];
    div_ctl = '0;
    case (st_q)
      S_CLR: begin
        cen_we = 1'b1; sum_we = 1'b1;
      end
      S_IDLE: begin
        if (req_fire && req.data.req_type == REQ_LOAD &&
            32'(req.data.centroid_index) < MAX_CENTROIDS) begin
          cen_we = 1'b1; cen_wa = AW'(req.data.centroid_index); cen_wd = pt_in;
        end
        rd_a = '0;
      end
      S_ASN_W: rd_a = best_idx_q;
      S_ASN_RMW: begin
        if (cnt_rd_q != {COUNT_BITS{1'b1}}) begin
          sum_we = 1'b1; sum_wa = best_idx_q;
          sum_wd = sum_add; cnt_wd = cnt_rd_q + 1'b1;
        end
      end
      S_UPD_DIV: begin
        div_ctl.start = (cnt_rd_q != '0);
        div_ctl.neg = sum_sel[SUM_BITS-1];
      end
      // inactive centroids keep their value, all sums are cleared
      S_UPD_WR: begin
        cen_we = (32'(ptr_q) < 32'(n_used)); cen_wd = mean_q;
        sum_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; act_q <= CFG_BITS'(16); ptr_q <= '0;
      rsp_v_q <= 1'b0; cmp_v_q <= 1'b0; cmp_v2_q <= 1'b0;
      have_best_q <= 1'b0;
    end else begin
      if (cfg.valid) act_q <= cfg.data;
      if (rsp_v_q && rsp.ready) rsp_v_q <= 1'b0;
      cmp_v2_q <= cmp_v_q;
      case (st_q)
        S_CLR: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == NB'(MAX_CENTROIDS - 1)) begin
            st_q <= S_IDLE; ptr_q <= '0;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            rsp_q.answered_type <= req.data.req_type;
            rsp_q.converged <= 1'b0;
            rsp_q.nearest_cluster <= '0;
            pt_q <= pt_in;
            case (req.data.req_type)
              REQ_ASSIGN: begin
                st_q <= S_ASN; ptr_q <= NB'(1); cmp_v_q <= 1'b1;
                have_best_q <= 1'b0;
              end
              REQ_UPDATE: begin
                st_q <= S_UPD_RD; ptr_q <= '0; same_q <= 1'b1;
              end
              default: begin
                st_q <= S_RSP;
              end
            endcase
          end
        end
        // stream centroid reads; the distance follows through the memory read register and the dist stage 1 register
        S_ASN: begin
          if (ptr_q < n_used) begin
            ptr_q <= ptr_q + 1'b1;
            cmp_v_q <= 1'b1;
          end else cmp_v_q <= 1'b0;
          if (cmp_v2_q) begin
            if (!have_best_q || sq_dist <= best_q) begin
              best_q <= sq_dist; best_idx_q <= cmp2_q;
            end
            have_best_q <= 1'b1;
            if (32'(cmp2_q) == 32'(n_used) - 1) st_q <= S_ASN_W;
          end
        end
        S_ASN_W: st_q <= S_ASN_RMW;
        S_ASN_RMW: begin
          rsp_q.nearest_cluster <= IDX_BITS'(best_idx_q);
          st_q <= S_RSP;
        end
        S_UPD_RD: begin
          dim_q <= '0; st_q <= S_UPD_DIV;
        end
        S_UPD_DIV: begin
          st_q <= (cnt_rd_q != '0) ? S_UPD_WT : S_UPD_WR;
          if (cnt_rd_q == '0) mean_q <= '0;
        end
        S_UPD_WT: begin
          if (div_done) begin
            mean_q <= mean_next;
            if (dim_q == 2'(DIMS - 1)) st_q <= S_UPD_WR;
            else begin
              dim_q <= dim_q + 1'b1; st_q <= S_UPD_DIV;
            end
          end
        end
        S_UPD_WR: begin
          if (32'(ptr_q) < 32'(n_used) && mean_q != cen_rd_q) same_q <= 1'b0;
          if (ptr_q == NB'(MAX_CENTROIDS - 1)) begin
            rsp_q.converged <= same_q &&
              !(32'(ptr_q) < 32'(n_used) && mean_q != cen_rd_q);
            st_q <= S_RSP; ptr_q <= '0;
          end else begin
            ptr_q <= ptr_q + 1'b1; st_q <= S_UPD_RD;
          end
        end
        S_RSP: begin
          if (!rsp_v_q) begin
            rsp_v_q <= 1'b1; st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // index of the entry read this cycle, delayed along with its data
  always_ff @(posedge clk_i) begin
    cmp_q  <= {1'b0, rd_a};
    cmp2_q <= cmp_q[AW-1:0];
  end

endmodule

// ===== rtl/kmau_checker.sv =====
// kmau_checker: port-level checks of the k-means block, bound to the top
// depends on kmau_pkg and the channel interfaces
module kmau_checker import kmau_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  // response held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed under stall");

  // only assign transactions name a cluster
  a_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.answered_type != REQ_ASSIGN |-> rsp_data.nearest_cluster == '0)
    else $error("nearest cluster on non-assign");

  // converged only for update
  a_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.converged |-> rsp_data.answered_type == REQ_UPDATE)
    else $error("converged on non-update");

  // a request is not taken in the cycle right after one was taken
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("back to back accept");

endmodule

bind kmeans_assign_update kmau_checker u_kmau_checker (
  .clk_i (clk_i), .rst_ni (rst_ni),
  .req_valid (req.valid), .req_ready (req.ready),
  .rsp_valid (rsp.valid), .rsp_ready (rsp.ready), .rsp_data (rsp.data)
);
